### rtl/dpfr_pkg.sv
`default_nettype none

package dpfr_pkg;

   // Parameter defaults
   localparam int NUM_SEGMENTS_DEF      = 8;
   localparam int PAGES_PER_SEGMENT_DEF = 256;
   localparam int ADDR_WIDTH_DEF        = 32;

   // Fixed port widths
   localparam int PORT_ADDR_W = 32;
   localparam int SIZE_W      = 25;
   localparam int LEN_W       = 17;
   localparam int PERM_W      = 3;
   localparam int IDX_W       = 3;
   localparam int PIDX_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int SHIFT_W     = 5;
   localparam int SEGCNT_W    = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   // Request kinds
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FAULT = 1'b1;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_SHIFT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_COUNT  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OUTSIDE  = 3'd0,
      ST_MAPPED   = 3'd1,
      ST_MAP_PAGE = 3'd2,
      ST_LOADED   = 3'd3,
      ST_REJECTED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FIN_LOADED   = 2'd0,
      FIN_REJECTED = 2'd1,
      FIN_OUTSIDE  = 2'd2,
      FIN_FAULT    = 2'd3
   } fin_kind_type;

   typedef struct packed {
      logic         capture;
      logic         eval;
      logic         clear;
      logic         scan;
      logic         page;
      logic         finish;
      fin_kind_type kind;
   } dp_cmd_type;

   typedef struct packed {
      logic req_fault;
      logic load_reject;
      logic clear_last;
      logic scan_done;
      logic scan_hit;
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/dpfr_ctrl.sv
`default_nettype none

module dpfr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire dpfr_pkg::dp_sts_type sts,
   output dpfr_pkg::dp_cmd_type      cmd
);
   import dpfr_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_EVAL  = 6'b000010,
      S_CLEAR = 6'b000100,
      S_SCAN  = 6'b001000,
      S_PAGE  = 6'b010000,
      S_CHECK = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = FIN_LOADED;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = sts.req_fault ? S_SCAN : S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.load_reject) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_REJECTED;
               state_in   = S_IDLE;
            end else begin
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_LOADED;
               state_in   = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            priority if (sts.scan_done) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_OUTSIDE;
               state_in   = S_IDLE;
            end else if (sts.scan_hit) begin
               state_in = S_PAGE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_PAGE: begin
            cmd.page = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.finish = 1'b1;
            cmd.kind   = FIN_FAULT;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");
   a_page_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PAGE) |=> (state_ff == S_CHECK))
      else $error("page lookup not followed by check");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == S_IDLE))
      else $error("controller not idle after finishing a transaction");
`endif

endmodule

`default_nettype wire

### rtl/dpfr_datapath.sv
`default_nettype none

module dpfr_datapath #(
   parameter int NUM_SEGMENTS      = dpfr_pkg::NUM_SEGMENTS_DEF,
   parameter int PAGES_PER_SEGMENT = dpfr_pkg::PAGES_PER_SEGMENT_DEF,
   parameter int ADDR_WIDTH        = dpfr_pkg::ADDR_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire dpfr_pkg::dp_cmd_type                  cmd,
   output dpfr_pkg::dp_sts_type                       sts,
   input  wire logic                                  csr_we,
   input  wire logic [dpfr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [dpfr_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic                                  req_type,
   input  wire logic [dpfr_pkg::IDX_W-1:0]            req_seg_index,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0]      req_seg_vaddr,
   input  wire logic [dpfr_pkg::SIZE_W-1:0]           req_seg_mem_size,
   input  wire logic [dpfr_pkg::SIZE_W-1:0]           req_seg_file_size,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0]      req_seg_offset,
   input  wire logic [dpfr_pkg::PERM_W-1:0]           req_seg_perm,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0]      req_fault_addr,
   output logic                                       rsp_strobe,
   output logic [dpfr_pkg::STATUS_W-1:0]              rsp_status,
   output logic [dpfr_pkg::IDX_W-1:0]                 rsp_hit_segment,
   output logic [dpfr_pkg::PIDX_W-1:0]                rsp_page_index,
   output logic [dpfr_pkg::PORT_ADDR_W-1:0]           rsp_map_addr,
   output logic [dpfr_pkg::LEN_W-1:0]                 rsp_alloc_len,
   output logic [dpfr_pkg::LEN_W-1:0]                 rsp_copy_len,
   output logic [dpfr_pkg::PORT_ADDR_W-1:0]           rsp_file_offset,
   output logic [dpfr_pkg::PERM_W-1:0]                rsp_page_perm
);
   import dpfr_pkg::*;

   localparam int AW         = (ADDR_WIDTH < PORT_ADDR_W) ? ADDR_WIDTH : PORT_ADDR_W;
   localparam int DW         = (AW > SIZE_W) ? AW : SIZE_W;
   localparam int SEG_W      = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int CNT_W      = $clog2(NUM_SEGMENTS + 1);
   localparam int PG_W       = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
   localparam int MP_W       = $clog2(PAGES_PER_SEGMENT + 1);
   localparam int MA_W       = SEG_W + PG_W;
   localparam int MARK_DEPTH = NUM_SEGMENTS * (2 ** PG_W);
   localparam int ICMP_W     = IDX_W + CNT_W;
   localparam int CCMP_W     = SEGCNT_W + CNT_W;

   localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd9;
   localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd16;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd12;

   // raw page number of a byte offset at the smallest page size
   localparam int PGR_W   = SIZE_W - 9;
   localparam int PAGES_W = PGR_W + 1;

   function automatic logic [PAGES_W-1:0] ceil_pages(input logic [SIZE_W-1:0]  bytes,
                                                     input logic [SHIFT_W-1:0] s,
                                                     input logic [SIZE_W-1:0]  m);
      logic [SIZE_W-1:0] q;
      q = bytes >> s;
      return PAGES_W'(q) + PAGES_W'((bytes & m) != '0);
   endfunction

   // CSRs
   logic [SHIFT_W-1:0]  page_shift_ff;
   logic [SEGCNT_W-1:0] seg_count_ff;

   // captured transaction
   logic [IDX_W-1:0]       req_idx_ff;
   logic [AW-1:0]          addr_ff;
   logic [SIZE_W-1:0]      msz_ff;
   logic [SIZE_W-1:0]      fsz_ff;
   logic [PORT_ADDR_W-1:0] offset_ff;
   logic [PERM_W-1:0]      perm_ff;

   // descriptor table
   logic [AW-1:0]          seg_base_ff      [NUM_SEGMENTS];
   logic [SIZE_W-1:0]      seg_size_ff      [NUM_SEGMENTS];
   logic [SIZE_W-1:0]      seg_backed_ff    [NUM_SEGMENTS];
   logic [PORT_ADDR_W-1:0] seg_file_base_ff [NUM_SEGMENTS];
   logic [PERM_W-1:0]      seg_prot_ff      [NUM_SEGMENTS];
   logic [MP_W-1:0]        seg_mem_pages_ff [NUM_SEGMENTS];
   logic [MP_W-1:0]        seg_file_pages_ff[NUM_SEGMENTS];

   // mapped bitmap
   logic mark_mem [MARK_DEPTH];
   logic mark_rd_ff;

   // walk state
   logic [PG_W-1:0]   clr_ff;
   logic [CNT_W-1:0]  scan_ff;
   logic [SIZE_W-1:0] off_ff;
   logic [SEG_W-1:0]  hit_slot_ff;
   logic [PG_W-1:0]   pg_ff;

   // result registers
   logic                   rsp_strobe_ff;
   status_type             rsp_status_ff;
   logic [IDX_W-1:0]       rsp_hit_ff;
   logic [PIDX_W-1:0]      rsp_pidx_ff;
   logic [PORT_ADDR_W-1:0] rsp_map_ff;
   logic [LEN_W-1:0]       rsp_alloc_ff;
   logic [LEN_W-1:0]       rsp_copy_ff;
   logic [PORT_ADDR_W-1:0] rsp_foff_ff;
   logic [PERM_W-1:0]      rsp_perm_ff;

   status_type             rsp_status_in;
   logic [IDX_W-1:0]       rsp_hit_in;
   logic [PIDX_W-1:0]      rsp_pidx_in;
   logic [PORT_ADDR_W-1:0] rsp_map_in;
   logic [LEN_W-1:0]       rsp_alloc_in;
   logic [LEN_W-1:0]       rsp_copy_in;
   logic [PORT_ADDR_W-1:0] rsp_foff_in;
   logic [PERM_W-1:0]      rsp_perm_in;

   logic [SHIFT_W-1:0]     sh;
   logic [LEN_W-1:0]       psize;
   logic [SIZE_W-1:0]      pmask;
   logic [SIZE_W-1:0]      fsz_c;
   logic [PAGES_W-1:0]     mp;
   logic [PAGES_W-1:0]     fp;
   logic                   load_reject;
   logic [SEG_W-1:0]       ld_slot;
   logic [CNT_W-1:0]       cnt_eff;
   logic [SEG_W-1:0]       scan_slot;
   logic [AW-1:0]          diff;
   logic                   scan_done;
   logic                   scan_hit;
   logic [PGR_W-1:0]       pg_raw;
   logic [PG_W-1:0]        pg_c;
   logic [PORT_ADDR_W-1:0] pg_bytes;
   logic [AW-1:0]          map_sum;
   logic [PORT_ADDR_W-1:0] file_sum;
   logic [MP_W-1:0]        pg_next;
   logic [SIZE_W-1:0]      size_rem;
   logic [SIZE_W-1:0]      back_rem;
   logic [LEN_W-1:0]       alloc_len;
   logic [LEN_W-1:0]       copy_len;
   logic                   mark_we;
   logic [MA_W-1:0]        mark_wa;
   logic                   mark_wd;
   logic                   clear_last;

   // effective page size
   always_comb begin
      priority if (page_shift_ff < SHIFT_MIN) begin
         sh = SHIFT_MIN;
      end else if (page_shift_ff > SHIFT_MAX) begin
         sh = SHIFT_MAX;
      end else begin
         sh = page_shift_ff;
      end
   end

   assign psize = LEN_W'(1) << sh;
   assign pmask = (SIZE_W'(1) << sh) - SIZE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= SHIFT_RESET;
         seg_count_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PAGE_SHIFT: begin
               page_shift_ff <= csr_wdata[SHIFT_W-1:0];
            end
            CSR_SEG_COUNT: begin
               seg_count_ff <= csr_wdata[SEGCNT_W-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_idx_ff <= req_seg_index;
         addr_ff    <= (req_type == REQ_FAULT) ? AW'(req_fault_addr) : AW'(req_seg_vaddr);
         msz_ff     <= req_seg_mem_size;
         fsz_ff     <= req_seg_file_size;
         offset_ff  <= req_seg_offset;
         perm_ff    <= req_seg_perm;
      end
   end

   // load evaluation
   assign fsz_c       = (fsz_ff > msz_ff) ? msz_ff : fsz_ff;
   assign mp          = ceil_pages(msz_ff, sh, pmask);
   assign fp          = ceil_pages(fsz_c, sh, pmask);
   assign load_reject = (ICMP_W'(req_idx_ff) >= ICMP_W'(NUM_SEGMENTS))
                        || (mp > PAGES_W'(PAGES_PER_SEGMENT));
   assign ld_slot     = SEG_W'(req_idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.eval && !load_reject) begin
         seg_base_ff[ld_slot]      <= addr_ff;
         seg_size_ff[ld_slot]      <= msz_ff;
         seg_backed_ff[ld_slot]    <= fsz_c;
         seg_file_base_ff[ld_slot] <= offset_ff;
         seg_prot_ff[ld_slot]      <= perm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_mem_pages_ff[i]  <= '0;
            seg_file_pages_ff[i] <= '0;
         end
      end else if (cmd.eval && !load_reject) begin
         seg_mem_pages_ff[ld_slot]  <= MP_W'(mp);
         seg_file_pages_ff[ld_slot] <= MP_W'(fp);
      end
   end

   // bitmap row clear, one page per cycle
   assign clear_last = (clr_ff == PG_W'(PAGES_PER_SEGMENT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.eval) begin
         clr_ff <= '0;
      end else if (cmd.clear && !clear_last) begin
         clr_ff <= clr_ff + PG_W'(1);
      end
   end

   // segment search, one slot per cycle
   assign cnt_eff   = (CCMP_W'(seg_count_ff) > CCMP_W'(NUM_SEGMENTS))
                      ? CNT_W'(NUM_SEGMENTS) : CNT_W'(seg_count_ff);
   assign scan_slot = SEG_W'(scan_ff);
   assign scan_done = (scan_ff >= cnt_eff);
   assign diff      = addr_ff - seg_base_ff[scan_slot];
   assign scan_hit  = !scan_done && (addr_ff >= seg_base_ff[scan_slot])
                      && (DW'(diff) < DW'(seg_size_ff[scan_slot]));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else if (cmd.capture) begin
         scan_ff <= '0;
      end else if (cmd.scan && !scan_done && !scan_hit) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && scan_hit) begin
         off_ff      <= SIZE_W'(diff);
         hit_slot_ff <= scan_slot;
      end
   end

   // page number, clamped to the row
   assign pg_raw = PGR_W'(off_ff >> sh);
   assign pg_c   = (pg_raw >= PGR_W'(PAGES_PER_SEGMENT))
                   ? PG_W'(PAGES_PER_SEGMENT - 1) : PG_W'(pg_raw);

   always_ff @(posedge clock) begin
      if (cmd.page) begin
         pg_ff <= pg_c;
      end
   end

   assign mark_we = cmd.clear || (cmd.finish && (cmd.kind == FIN_FAULT) && !mark_rd_ff);
   assign mark_wa = cmd.clear ? {ld_slot, clr_ff} : {hit_slot_ff, pg_ff};
   assign mark_wd = !cmd.clear;

   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (cmd.page) begin
         mark_rd_ff <= mark_mem[{hit_slot_ff, pg_c}];
      end
   end

   // page mapping results
   assign pg_bytes = PORT_ADDR_W'(pg_ff) << sh;
   assign map_sum  = seg_base_ff[hit_slot_ff] + AW'(pg_bytes);
   assign file_sum = seg_file_base_ff[hit_slot_ff] + pg_bytes;
   assign pg_next  = MP_W'(pg_ff) + MP_W'(1);
   assign size_rem = seg_size_ff[hit_slot_ff] & pmask;
   assign back_rem = seg_backed_ff[hit_slot_ff] & pmask;

   assign alloc_len = ((pg_next == seg_mem_pages_ff[hit_slot_ff]) && (size_rem != '0))
                      ? LEN_W'(size_rem) : psize;

   always_comb begin
      priority if (MP_W'(pg_ff) >= seg_file_pages_ff[hit_slot_ff]) begin
         copy_len = '0;
      end else if ((pg_next == seg_file_pages_ff[hit_slot_ff]) && (back_rem != '0)) begin
         copy_len = LEN_W'(back_rem);
      end else begin
         copy_len = psize;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
      end
   end

   // result fields; those without meaning for a status stay zero
   always_comb begin
      rsp_status_in = ST_OUTSIDE;
      rsp_hit_in    = '0;
      rsp_pidx_in   = '0;
      rsp_map_in    = '0;
      rsp_alloc_in  = '0;
      rsp_copy_in   = '0;
      rsp_foff_in   = '0;
      rsp_perm_in   = '0;
      unique case (cmd.kind)
         FIN_LOADED: begin
            rsp_status_in = ST_LOADED;
            rsp_hit_in    = req_idx_ff;
         end
         FIN_REJECTED: begin
            rsp_status_in = ST_REJECTED;
            rsp_hit_in    = req_idx_ff;
         end
         FIN_OUTSIDE: begin
            rsp_status_in = ST_OUTSIDE;
         end
         FIN_FAULT: begin
            rsp_hit_in  = IDX_W'(hit_slot_ff);
            rsp_pidx_in = PIDX_W'(pg_ff);
            if (mark_rd_ff) begin
               rsp_status_in = ST_MAPPED;
            end else begin
               rsp_status_in = ST_MAP_PAGE;
               rsp_map_in    = PORT_ADDR_W'(map_sum);
               rsp_alloc_in  = alloc_len;
               rsp_copy_in   = copy_len;
               rsp_foff_in   = file_sum;
               rsp_perm_in   = seg_prot_ff[hit_slot_ff];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_pidx_ff   <= rsp_pidx_in;
         rsp_map_ff    <= rsp_map_in;
         rsp_alloc_ff  <= rsp_alloc_in;
         rsp_copy_ff   <= rsp_copy_in;
         rsp_foff_ff   <= rsp_foff_in;
         rsp_perm_ff   <= rsp_perm_in;
      end
   end

   assign sts.req_fault   = (req_type == REQ_FAULT);
   assign sts.load_reject = load_reject;
   assign sts.clear_last  = clear_last;
   assign sts.scan_done   = scan_done;
   assign sts.scan_hit    = scan_hit;

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit_segment = rsp_hit_ff;
   assign rsp_page_index  = rsp_pidx_ff;
   assign rsp_map_addr    = rsp_map_ff;
   assign rsp_alloc_len   = rsp_alloc_ff;
   assign rsp_copy_len    = rsp_copy_ff;
   assign rsp_file_offset = rsp_foff_ff;
   assign rsp_page_perm   = rsp_perm_ff;

`ifndef SYNTHESIS
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(cmd.finish))
      else $error("result strobe without a finished transaction");
   a_clear_range: assert property (@(posedge clock) disable iff (reset)
      clr_ff <= PG_W'(PAGES_PER_SEGMENT - 1))
      else $error("bitmap clear pointer past end of row");
`endif

endmodule

`default_nettype wire

### rtl/demand_page_fault_resolver_top.sv
`default_nettype none

// Demand page fault resolver.
// Request channel: a transaction is taken on a clock edge with start high and busy
// low. req_type selects a segment load (writes one descriptor slot and clears that
// slot's mapped-page bitmap) or a fault lookup (finds the first segment holding
// req_fault_addr and reports outside / already mapped / map this page).
// Response channel: one result per transaction, shown for exactly one cycle with
// rsp_strobe high. The receiver cannot stall; busy drops in the strobe cycle, so
// the next transaction may start then.
// CSR port: csr_we/csr_index/csr_wdata write page_shift (index 0) and
// segment_count (index 1); write only while busy is low.
// Sequence, accept edge to strobe cycle:
//   load accepted   : evaluate, then bitmap row cleared one bit per cycle
//                     through the single bitmap write port, then the result stage
//   load rejected   : evaluate, then the result stage
//   fault, hit slot k: slots 0 .. k compared one per cycle, then a registered
//                     bitmap read and the result stage
//   fault, outside  : segment_count slots scanned (count limited to NUM_SEGMENTS)
// Reset (synchronous): page_shift = 12, segment_count = 0, page counts cleared,
// controller idle. Descriptor slots hold nothing valid until loaded.

module demand_page_fault_resolver_top #(
   parameter int NUM_SEGMENTS      = dpfr_pkg::NUM_SEGMENTS_DEF,
   parameter int PAGES_PER_SEGMENT = dpfr_pkg::PAGES_PER_SEGMENT_DEF,
   parameter int ADDR_WIDTH        = dpfr_pkg::ADDR_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_type,
   input  wire logic [dpfr_pkg::IDX_W-1:0]       req_seg_index,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0] req_seg_vaddr,
   input  wire logic [dpfr_pkg::SIZE_W-1:0]      req_seg_mem_size,
   input  wire logic [dpfr_pkg::SIZE_W-1:0]      req_seg_file_size,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0] req_seg_offset,
   input  wire logic [dpfr_pkg::PERM_W-1:0]      req_seg_perm,
   input  wire logic [dpfr_pkg::PORT_ADDR_W-1:0] req_fault_addr,
   // response
   output logic                                  rsp_strobe,
   output logic [dpfr_pkg::STATUS_W-1:0]         rsp_status,
   output logic [dpfr_pkg::IDX_W-1:0]            rsp_hit_segment,
   output logic [dpfr_pkg::PIDX_W-1:0]           rsp_page_index,
   output logic [dpfr_pkg::PORT_ADDR_W-1:0]      rsp_map_addr,
   output logic [dpfr_pkg::LEN_W-1:0]            rsp_alloc_len,
   output logic [dpfr_pkg::LEN_W-1:0]            rsp_copy_len,
   output logic [dpfr_pkg::PORT_ADDR_W-1:0]      rsp_file_offset,
   output logic [dpfr_pkg::PERM_W-1:0]           rsp_page_perm,
   // CSR writes
   input  wire logic                             csr_we,
   input  wire logic [dpfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [dpfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import dpfr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer: accept, load evaluate/clear, slot scan, page check
   dpfr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // CSRs, descriptor table, bitmap memory and result registers
   dpfr_datapath #(
      .NUM_SEGMENTS      (NUM_SEGMENTS),
      .PAGES_PER_SEGMENT (PAGES_PER_SEGMENT),
      .ADDR_WIDTH        (ADDR_WIDTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_type          (req_type),
      .req_seg_index     (req_seg_index),
      .req_seg_vaddr     (req_seg_vaddr),
      .req_seg_mem_size  (req_seg_mem_size),
      .req_seg_file_size (req_seg_file_size),
      .req_seg_offset    (req_seg_offset),
      .req_seg_perm      (req_seg_perm),
      .req_fault_addr    (req_fault_addr),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_hit_segment   (rsp_hit_segment),
      .rsp_page_index    (rsp_page_index),
      .rsp_map_addr      (rsp_map_addr),
      .rsp_alloc_len     (rsp_alloc_len),
      .rsp_copy_len      (rsp_copy_len),
      .rsp_file_offset   (rsp_file_offset),
      .rsp_page_perm     (rsp_page_perm)
   );

endmodule

`default_nettype wire

### dv/demand_page_fault_resolver_top_tb.sv
`timescale 1ns / 100ps

import dpfr_pkg::*;

// One request transaction, as it is put on the req_ ports.
typedef struct packed {
   logic                   req_type;
   logic [IDX_W-1:0]       seg_index;
   logic [PORT_ADDR_W-1:0] seg_vaddr;
   logic [SIZE_W-1:0]      seg_mem_size;
   logic [SIZE_W-1:0]      seg_file_size;
   logic [PORT_ADDR_W-1:0] seg_offset;
   logic [PERM_W-1:0]      seg_perm;
   logic [PORT_ADDR_W-1:0] fault_addr;
} fault_req_t;

// One response transaction, as it shows on the rsp_ ports.
typedef struct packed {
   status_type             status;
   logic [IDX_W-1:0]       hit_segment;
   logic [PIDX_W-1:0]      page_index;
   logic [PORT_ADDR_W-1:0] map_addr;
   logic [LEN_W-1:0]       alloc_len;
   logic [LEN_W-1:0]       copy_len;
   logic [PORT_ADDR_W-1:0] file_offset;
   logic [PERM_W-1:0]      page_perm;
} fault_rsp_t;

class fault_resolver_scoreboard;
   // descriptor table and mapped-page bitmap
   logic [PORT_ADDR_W-1:0] seg_start  [NUM_SEGMENTS_DEF];
   logic [SIZE_W-1:0]      seg_len    [NUM_SEGMENTS_DEF];
   logic [SIZE_W-1:0]      seg_backed [NUM_SEGMENTS_DEF];
   logic [PORT_ADDR_W-1:0] seg_file   [NUM_SEGMENTS_DEF];
   logic [PERM_W-1:0]      seg_prot   [NUM_SEGMENTS_DEF];
   int unsigned            mem_pages  [NUM_SEGMENTS_DEF];
   int unsigned            file_pages [NUM_SEGMENTS_DEF];
   bit                     page_mapped [NUM_SEGMENTS_DEF][PAGES_PER_SEGMENT_DEF];
   logic [SHIFT_W-1:0]     shift_reg;
   logic [SEGCNT_W-1:0]    count_reg;
   fault_rsp_t             outcomes_due [$];
   int                     mismatch_count;

   function new();
      for (int i = 0; i < NUM_SEGMENTS_DEF; i++) begin
         seg_start[i]  = '0;
         seg_len[i]    = '0;
         seg_backed[i] = '0;
         seg_file[i]   = '0;
         seg_prot[i]   = '0;
         mem_pages[i]  = 0;
         file_pages[i] = 0;
         for (int p = 0; p < PAGES_PER_SEGMENT_DEF; p++) page_mapped[i][p] = 1'b0;
      end
      shift_reg      = 5'd12;
      count_reg      = '0;
      mismatch_count = 0;
   endfunction

   function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_PAGE_SHIFT) shift_reg = data;
      else count_reg = data[SEGCNT_W-1:0];
   endfunction

   // page shift clamped to 9..16
   function int unsigned page_bits();
      if (shift_reg < 9) return 9;
      if (shift_reg > 16) return 16;
      return shift_reg;
   endfunction

   function int unsigned search_depth();
      return (count_reg > NUM_SEGMENTS_DEF) ? NUM_SEGMENTS_DEF : count_reg;
   endfunction

   function int unsigned page_count(int unsigned bytes, int unsigned sh);
      int unsigned n;
      n = bytes >> sh;
      if ((bytes & ((1 << sh) - 1)) != 0) n++;
      return n;
   endfunction

   function fault_rsp_t resolve_request(fault_req_t rq);
      fault_rsp_t        r;
      int unsigned       sh, psize, pmask, pg, mp, idx;
      logic [SIZE_W-1:0] fsz;
      logic [31:0]       off;
      r     = '0;
      sh    = page_bits();
      psize = 1 << sh;
      pmask = psize - 1;
      if (rq.req_type == REQ_LOAD) begin
         idx = rq.seg_index;
         r.hit_segment = rq.seg_index;
         fsz = (rq.seg_file_size > rq.seg_mem_size) ? rq.seg_mem_size : rq.seg_file_size;
         mp  = page_count(rq.seg_mem_size, sh);
         if (idx >= NUM_SEGMENTS_DEF || mp > PAGES_PER_SEGMENT_DEF) begin
            r.status = ST_REJECTED;
            return r;
         end
         seg_start[idx]  = rq.seg_vaddr;
         seg_len[idx]    = rq.seg_mem_size;
         seg_backed[idx] = fsz;
         seg_file[idx]   = rq.seg_offset;
         seg_prot[idx]   = rq.seg_perm;
         mem_pages[idx]  = mp;
         file_pages[idx] = page_count(fsz, sh);
         for (int p = 0; p < PAGES_PER_SEGMENT_DEF; p++) page_mapped[idx][p] = 1'b0;
         r.status = ST_LOADED;
         return r;
      end
      // first slot whose [base, base + size) holds the address wins
      for (int i = 0; i < int'(search_depth()); i++) begin
         if (rq.fault_addr < seg_start[i]) continue;
         off = rq.fault_addr - seg_start[i];
         if (off >= seg_len[i]) continue;
         pg = off >> sh;
         if (pg >= PAGES_PER_SEGMENT_DEF) pg = PAGES_PER_SEGMENT_DEF - 1;
         r.hit_segment = IDX_W'(i);
         r.page_index  = PIDX_W'(pg);
         if (page_mapped[i][pg]) begin
            r.status = ST_MAPPED;
            return r;
         end
         r.alloc_len = LEN_W'(psize);
         if (pg + 1 == mem_pages[i] && (seg_len[i] & pmask) != 0)
            r.alloc_len = LEN_W'(seg_len[i] & pmask);
         if (pg >= file_pages[i])
            r.copy_len = '0;
         else if (pg + 1 == file_pages[i] && (seg_backed[i] & pmask) != 0)
            r.copy_len = LEN_W'(seg_backed[i] & pmask);
         else
            r.copy_len = LEN_W'(psize);
         page_mapped[i][pg] = 1'b1;
         r.status      = ST_MAP_PAGE;
         r.map_addr    = seg_start[i] + PORT_ADDR_W'(pg << sh);
         r.file_offset = seg_file[i] + PORT_ADDR_W'(pg << sh);
         r.page_perm   = seg_prot[i];
         return r;
      end
      r.status = ST_OUTSIDE;
      return r;
   endfunction

   function status_type note_request(fault_req_t rq);
      fault_rsp_t r;
      r = resolve_request(rq);
      outcomes_due.push_back(r);
      return r.status;
   endfunction

   task report(string msg);
      if (mismatch_count < 100) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task check_result(fault_rsp_t got);
      fault_rsp_t want;
      if (outcomes_due.size() == 0) begin
         report($sformatf("response with no transaction outstanding, status %0d",
                          got.status));
         return;
      end
      want = outcomes_due.pop_front();
      if (got.status !== want.status)
         report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.hit_segment !== want.hit_segment)
         report($sformatf("hit_segment got %0d want %0d", got.hit_segment, want.hit_segment));
      if (got.page_index !== want.page_index)
         report($sformatf("page_index got %0d want %0d", got.page_index, want.page_index));
      if (got.map_addr !== want.map_addr)
         report($sformatf("map_addr got %h want %h", got.map_addr, want.map_addr));
      if (got.alloc_len !== want.alloc_len)
         report($sformatf("alloc_len got %h want %h", got.alloc_len, want.alloc_len));
      if (got.copy_len !== want.copy_len)
         report($sformatf("copy_len got %h want %h", got.copy_len, want.copy_len));
      if (got.file_offset !== want.file_offset)
         report($sformatf("file_offset got %h want %h", got.file_offset, want.file_offset));
      if (got.page_perm !== want.page_perm)
         report($sformatf("page_perm got %0d want %0d", got.page_perm, want.page_perm));
   endtask
endclass

module demand_page_fault_resolver_top_tb;

   localparam int RANDOM_ITEMS = 700;
   localparam int QUIET_TAIL   = 60;       // last transactions go back to back
   localparam int DRAIN_CYCLES = 300;      // longer than a load clears its bitmap row
   localparam int CYCLE_LIMIT  = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic                   start             = 1'b0;
   logic                   busy;
   logic                   req_type          = REQ_LOAD;
   logic [IDX_W-1:0]       req_seg_index     = '0;
   logic [PORT_ADDR_W-1:0] req_seg_vaddr     = '0;
   logic [SIZE_W-1:0]      req_seg_mem_size  = '0;
   logic [SIZE_W-1:0]      req_seg_file_size = '0;
   logic [PORT_ADDR_W-1:0] req_seg_offset    = '0;
   logic [PERM_W-1:0]      req_seg_perm      = '0;
   logic [PORT_ADDR_W-1:0] req_fault_addr    = '0;

   // response channel
   logic                   rsp_strobe;
   logic [STATUS_W-1:0]    rsp_status;
   logic [IDX_W-1:0]       rsp_hit_segment;
   logic [PIDX_W-1:0]      rsp_page_index;
   logic [PORT_ADDR_W-1:0] rsp_map_addr;
   logic [LEN_W-1:0]       rsp_alloc_len;
   logic [LEN_W-1:0]       rsp_copy_len;
   logic [PORT_ADDR_W-1:0] rsp_file_offset;
   logic [PERM_W-1:0]      rsp_page_perm;

   // CSR port
   logic                   csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   fault_resolver_scoreboard sb;
   fault_rsp_t               observed;
   bit                       slot_loaded [NUM_SEGMENTS_DEF];
   logic [31:0]              recent_faults [$];
   int                       items_sent   = 0;
   int                       quiet_from   = 32'h7fff_ffff;
   int unsigned              cycle_count  = 0;

   demand_page_fault_resolver_top u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_seg_index     (req_seg_index),
      .req_seg_vaddr     (req_seg_vaddr),
      .req_seg_mem_size  (req_seg_mem_size),
      .req_seg_file_size (req_seg_file_size),
      .req_seg_offset    (req_seg_offset),
      .req_seg_perm      (req_seg_perm),
      .req_fault_addr    (req_fault_addr),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_hit_segment   (rsp_hit_segment),
      .rsp_page_index    (rsp_page_index),
      .rsp_map_addr      (rsp_map_addr),
      .rsp_alloc_len     (rsp_alloc_len),
      .rsp_copy_len      (rsp_copy_len),
      .rsp_file_offset   (rsp_file_offset),
      .rsp_page_perm     (rsp_page_perm),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", sb.outcomes_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Response monitor: strobe lasts exactly one cycle, take it at the closing edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         observed.status      = status_type'(rsp_status);
         observed.hit_segment = rsp_hit_segment;
         observed.page_index  = rsp_page_index;
         observed.map_addr    = rsp_map_addr;
         observed.alloc_len   = rsp_alloc_len;
         observed.copy_len    = rsp_copy_len;
         observed.file_offset = rsp_file_offset;
         observed.page_perm   = rsp_page_perm;
         sb.check_result(observed);
      end
   end

   // Slots 0 .. n-1 all hold a descriptor; segment_count goes past n only when n is
   // NUM_SEGMENTS_DEF, so a fault search never touches a slot that was not written.
   function automatic int unsigned loaded_prefix();
      int unsigned n;
      n = 0;
      while (n < NUM_SEGMENTS_DEF && slot_loaded[n]) n++;
      return n;
   endfunction

   // Fields a transaction does not use still get random values.
   function automatic fault_req_t segment_load(logic [2:0] idx, logic [31:0] vaddr,
                                               int unsigned msz, int unsigned fsz,
                                               logic [31:0] offset, logic [2:0] perm);
      fault_req_t rq;
      rq.req_type      = REQ_LOAD;
      rq.seg_index     = idx;
      rq.seg_vaddr     = vaddr;
      rq.seg_mem_size  = SIZE_W'(msz);
      rq.seg_file_size = SIZE_W'(fsz);
      rq.seg_offset    = offset;
      rq.seg_perm      = perm;
      rq.fault_addr    = $urandom;
      return rq;
   endfunction

   function automatic fault_req_t access_fault(logic [31:0] addr);
      fault_req_t rq;
      rq.req_type      = REQ_FAULT;
      rq.seg_index     = IDX_W'($urandom);
      rq.seg_vaddr     = $urandom;
      rq.seg_mem_size  = SIZE_W'($urandom);
      rq.seg_file_size = SIZE_W'($urandom);
      rq.seg_offset    = $urandom;
      rq.seg_perm      = PERM_W'($urandom);
      rq.fault_addr    = addr;
      return rq;
   endfunction

   // Mostly well-formed descriptors of a few pages; some empty, some oversized,
   // file size sometimes above memory size; bases sometimes overlap a live slot.
   function automatic fault_req_t random_load();
      int unsigned sh, pages, msz, fsz, pick, top, s;
      logic [2:0]  idx;
      logic [31:0] vaddr;
      sh   = sb.page_bits();
      pick = $urandom_range(0, 99);
      if (pick < 5)
         msz = 0;
      else if (pick < 15)
         msz = $urandom_range((PAGES_PER_SEGMENT_DEF << sh) + 1, 25'h1FF_FFFF);
      else begin
         pages = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                            : $urandom_range(1, PAGES_PER_SEGMENT_DEF);
         msz   = ((pages - 1) << sh) + $urandom_range(1, 1 << sh);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) fsz = $urandom_range(0, msz);
      else if (pick < 85) fsz = msz;
      else fsz = $urandom_range(0, 25'h1FF_FFFF);
      top = loaded_prefix();
      if (top < NUM_SEGMENTS_DEF && $urandom_range(0, 1) == 0) idx = 3'(top);
      else idx = 3'($urandom_range(0, 7));
      if (top != 0 && $urandom_range(0, 9) < 3) begin
         s     = $urandom_range(0, top - 1);
         vaddr = sb.seg_start[s] + $urandom_range(0, sb.seg_len[s]);
      end else
         vaddr = $urandom;
      return segment_load(idx, vaddr, msz, fsz, $urandom, 3'($urandom));
   endfunction

   // Mostly aimed at live segments: inside, page starts, last byte, one past
   // the end, one below the base; repeats give already-mapped hits.
   function automatic fault_req_t random_fault();
      int unsigned n, sh, s, pick;
      logic [31:0] base, addr;
      logic [24:0] len;
      n    = sb.search_depth();
      sh   = sb.page_bits();
      pick = $urandom_range(0, 99);
      if (n == 0 || pick < 10)
         addr = $urandom;
      else if (pick < 30 && recent_faults.size() != 0)
         addr = recent_faults[$urandom_range(0, recent_faults.size() - 1)];
      else begin
         s    = $urandom_range(0, n - 1);
         base = sb.seg_start[s];
         len  = sb.seg_len[s];
         case ($urandom_range(0, 5))
            0: addr = base + len;
            1: addr = base - 1;
            2: addr = base + len - 1;
            3: addr = base + ($urandom_range(0, len >> sh) << sh);
            default: addr = (len == 0) ? base : base + $urandom_range(0, len - 1);
         endcase
      end
      recent_faults.push_back(addr);
      if (recent_faults.size() > 16) void'(recent_faults.pop_front());
      return access_fault(addr);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_count();
      int unsigned top, low;
      top = loaded_prefix();
      if (top == NUM_SEGMENTS_DEF && $urandom_range(0, 3) == 0) low = $urandom_range(9, 15);
      else if ($urandom_range(0, 1) == 0) low = top;
      else low = $urandom_range(0, top);
      // bit 4 is dropped by the 4-bit register
      return {1'($urandom_range(0, 1)), 4'(low)};
   endfunction

   // Put one transaction on the request ports and hold it until taken.
   task automatic issue_item(input fault_req_t rq);
      status_type outcome;
      int         gap;
      gap = (items_sent < quiet_from && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_type          <= rq.req_type;
      req_seg_index     <= rq.seg_index;
      req_seg_vaddr     <= rq.seg_vaddr;
      req_seg_mem_size  <= rq.seg_mem_size;
      req_seg_file_size <= rq.seg_file_size;
      req_seg_offset    <= rq.seg_offset;
      req_seg_perm      <= rq.seg_perm;
      req_fault_addr    <= rq.fault_addr;
      @(posedge clock);
      while (busy) @(posedge clock);
      outcome = sb.note_request(rq);
      if (rq.req_type == REQ_LOAD && outcome == ST_LOADED) slot_loaded[rq.seg_index] = 1'b1;
      items_sent++;
   endtask

   // Stop issuing and wait until every response is in and busy is low.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.outcomes_due.size() != 0 || busy) @(posedge clock);
   endtask

   // Only called after settle(); the idle cycle keeps each step to one write of csr_we.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_register(idx, data);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part ----
      // segment_count is 0 after reset: every fault lands outside
      issue_item(access_fault(32'hFFFF_FFFF));
      settle();
      write_csr(CSR_PAGE_SHIFT, 5'd12);
      // slot 0: 3 pages, partial last page; 2 file pages; file offset wraps
      issue_item(segment_load(3'd0, 32'h0001_0000, 'h2800, 'h1800, 32'hFFFF_F000, 3'b101));
      // slot 1: top of address space; file size above memory size gets clamped
      issue_item(segment_load(3'd1, 32'hFFFF_E000, 'h2000, 'h3000, 32'h0, 3'b111));
      // slot 2: overlaps slot 0, no file data
      issue_item(segment_load(3'd2, 32'h0001_1000, 'h1000, 'h0, 32'h100, 3'b000));
      // slot 3: zero-size segment at address 0
      issue_item(segment_load(3'd3, 32'h0, 'h0, 'h0, 32'h0, 3'b010));
      // 2^24 bytes at 4 KiB pages is far over the per-segment page budget
      issue_item(segment_load(3'd4, 32'h2000_0000, 'h100_0000, 'h0, 32'h0, 3'b001));
      // exactly the page budget
      issue_item(segment_load(3'd4, 32'h2000_0000, 'h10_0000, 'h10_0000, 32'h1234_5678,
                              3'b110));
      settle();
      write_csr(CSR_SEG_COUNT, 5'd5);
      issue_item(access_fault(32'h0001_0000));   // map page 0
      issue_item(access_fault(32'h0001_0000));   // already mapped
      issue_item(access_fault(32'h0001_1000));   // slot 0 wins over slot 2, partial copy
      issue_item(access_fault(32'h0001_27FF));   // last page, partial alloc, no copy
      issue_item(access_fault(32'h0001_2800));   // end bound is exclusive
      issue_item(access_fault(32'h0000_FFFF));   // just below the base
      issue_item(access_fault(32'h0000_0000));   // zero-size segment never hits
      issue_item(access_fault(32'hFFFF_FFFF));   // last byte of the address space
      issue_item(access_fault(32'h200F_FFFF));   // last page of a full segment
      // reload clears the slot's bitmap
      issue_item(segment_load(3'd0, 32'h0001_0000, 'h2800, 'h1800, 32'hFFFF_F000, 3'b101));
      issue_item(access_fault(32'h0001_0000));
      settle();
      write_csr(CSR_PAGE_SHIFT, 5'd31);          // clamps to 16
      issue_item(segment_load(3'd5, 32'h4000_0000, 'h100_0000, 'h1FF_FFFF, 32'h8000_0000,
                              3'b001));
      issue_item(segment_load(3'd6, 32'h5000_0000, 'h1FF_FFFF, 'h0, 32'h0, 3'b100));
      issue_item(segment_load(3'd6, 32'h5000_0000, 'h1, 'h1, 32'h0, 3'b100));
      issue_item(segment_load(3'd7, 32'h6000_0000, 'h1_0001, 'h8000, 32'hABCD_0000, 3'b011));
      settle();
      write_csr(CSR_SEG_COUNT, 5'd15);           // clamps to all eight slots
      issue_item(access_fault(32'h40FF_0000));   // 64 KiB alloc and copy
      issue_item(access_fault(32'h6001_0000));   // one-byte last page beyond file data
      settle();
      write_csr(CSR_PAGE_SHIFT, 5'd0);           // clamps to 9
      issue_item(access_fault(32'h2000_1000));
      issue_item(access_fault(32'h200F_FFFF));   // page number saturates at the last page

      // ---- random part: phases of loads, then a fault stream ----
      quiet_from = items_sent + RANDOM_ITEMS - QUIET_TAIL;
      while (items_sent < quiet_from + QUIET_TAIL) begin
         settle();
         write_csr(CSR_PAGE_SHIFT, ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                               : 5'($urandom_range(9, 16)));
         repeat ($urandom_range(1, 4)) issue_item(random_load());
         settle();
         write_csr(CSR_SEG_COUNT, pick_count());
         repeat ($urandom_range(8, 40))
            issue_item(($urandom_range(0, 9) == 0) ? random_load() : random_fault());
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
